@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the list engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, held off while reset is asserted.
`define ALI_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define ALI_ASSERT_MAIN(lbl, prop, msg) `ALI_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

@@ rtl/core/ali_pkg.sv @@
`default_nettype none

package ali_pkg;

	localparam int POS_W     = 5;
	localparam int CNT_W     = 5;
	localparam int VAL_W     = 32;
	localparam int DEPTH_DEF = 16;
	localparam logic [CNT_W-1:0] CAP_RST = 5'd16;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_POP    = 2'd2,
		REQ_DELETE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2
	} cell_op_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   pos;
		logic [VAL_W-1:0]   value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/ali_cell.sv @@
`default_nettype none

module ali_cell
	import ali_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW  = POS_W
) (
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [VAL_W-1:0] below_data,
	input  wire logic [VAL_W-1:0] above_data,
	output logic      [VAL_W-1:0] data
);

	localparam logic [IW-1:0] IDX_V = IW'(IDX);

	logic [IW-1:0]    pos_x;
	logic [VAL_W-1:0] data_q;

	assign pos_x = IW'(ctrl.pos);
	assign data  = data_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (IDX_V == pos_x) begin
					data_q <= ctrl.value;
				end else if (IDX_V > pos_x) begin
					data_q <= below_data;
				end
			end
			CELL_DELETE: begin
				if (IDX_V >= pos_x) begin
					data_q <= above_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/array_list_insert_delete.sv @@
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit words held in a row of cells that
// shift up, shift down, load or hold in parallel, so any append, insert, pop or
// delete is one row update; each result word is presented from the output
// register in the cycle after acceptance. A new request is taken whenever the
// output register is empty or being drained in the same cycle, so with results
// drained the sustained rate is one request per clock. Failed requests (list
// full, list empty, bad position) report a status and leave the list untouched.
// The limit is min(capacity, DEPTH); capacity resets to 16 and should be written
// only while no request is outstanding. No clearing pass follows reset: the
// count starts at zero and entries are read only after being written.
module array_list_insert_delete
	import ali_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              req_type,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] new_value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [VAL_W-1:0]      removed_value,
	output logic [1:0]                   status,
	output logic [CNT_W-1:0]             count_after,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CNT_W-1:0]        cfg_data
);

	`include "assert_macros.svh"

	localparam int DEPTH_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW      = (DEPTH_W > POS_W) ? DEPTH_W : POS_W;
	// count can never pass 31 since capacity is 5 bits
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int LIM_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
	localparam int NREAD   = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] removed_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_after_q;

	logic [VAL_W-1:0] cell_data [DEPTH];
	cell_ctrl_t       ctrl;

	req_t             req;
	logic             in_fire;
	logic             full;
	logic             empty;
	status_t          res_status;
	logic [CNT_W-1:0] res_count;
	logic [VAL_W-1:0] res_removed;
	logic [POS_W-1:0] del_pos;
	logic [VAL_W-1:0] rd_data;

	assign req       = req_t'(req_type);
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign full      = (count_q >= cap_q) || (count_q >= CNT_W'(LIM_MAX));
	assign empty     = (count_q == '0);
	assign del_pos   = (req == REQ_POP) ? '0 : position;

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < NREAD; i++) begin
			if (del_pos == POS_W'(i)) begin
				rd_data = cell_data[i];
			end
		end
	end

	always_comb begin
		res_status  = ST_OK;
		res_count   = count_q;
		res_removed = '0;
		ctrl.op     = CELL_HOLD;
		ctrl.pos    = position;
		ctrl.value  = new_value;
		case (req)
			REQ_APPEND: begin
				ctrl.pos = count_q;
				if (full) begin
					res_status = ST_FULL;
				end else begin
					ctrl.op   = CELL_INSERT;
					res_count = count_q + 1'b1;
				end
			end
			REQ_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (position > count_q) begin
					res_status = ST_BADPOS;
				end else begin
					ctrl.op   = CELL_INSERT;
					res_count = count_q + 1'b1;
				end
			end
			REQ_POP: begin
				ctrl.pos = '0;
				if (empty) begin
					res_status = ST_EMPTY;
				end else begin
					ctrl.op     = CELL_DELETE;
					res_count   = count_q - 1'b1;
					res_removed = rd_data;
				end
			end
			default: begin
				if (empty) begin
					res_status = ST_EMPTY;
				end else if (position >= count_q) begin
					res_status = ST_BADPOS;
				end else begin
					ctrl.op     = CELL_DELETE;
					res_count   = count_q - 1'b1;
					res_removed = rd_data;
				end
			end
		endcase
		if (!in_fire) begin
			ctrl.op = CELL_HOLD;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		ali_cell #(
			.IDX (g),
			.IW  (IW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.below_data (cell_data[(g > 0) ? g - 1 : g]),
			.above_data (cell_data[(g < DEPTH - 1) ? g + 1 : g]),
			.data       (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RST;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (in_fire) begin
				count_q     <= res_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			removed_q     <= res_removed;
			status_q      <= res_status;
			count_after_q <= res_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign count_after   = count_after_q;

	`ALI_ASSERT_MAIN(a_fail_keeps_count, in_fire && res_status != ST_OK |=> $stable(count_q), "failed request changed the count")
	`ALI_ASSERT_MAIN(a_append_grows, in_fire && req == REQ_APPEND && res_status == ST_OK |=> count_q == $past(count_q) + 5'd1, "append did not grow the count")
	`ALI_ASSERT_MAIN(a_word_count, out_valid_q && $past(in_fire) |-> count_after_q == count_q, "result count differs from list count")
	`ALI_ASSERT_MAIN(a_err_no_value, out_valid_q && status_q != ST_OK |-> removed_q == '0, "failed request returned a value")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
	import ali_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_WORDS = 50;

	typedef struct packed {
		logic [VAL_W-1:0] removed;
		status_t          st;
		logic [CNT_W-1:0] cnt;
	} outcome_t;

	typedef enum int {
		RX_STREAM,
		RX_COIN,
		RX_EVERY_THIRD,
		RX_SPARSE
	} rx_mode_t;

	// Shadow of the list plus the queue of outcomes still owed by the block.
	class list_scoreboard;
		logic [VAL_W-1:0] slots [DEPTH_DEF];
		int unsigned      used;
		int unsigned      cap;
		outcome_t         awaited[$];
		int               errors;
		int               req_seen [4];
		int               status_seen [4];

		function new();
			used = 0;
			cap = CAP_RST;
			errors = 0;
			foreach (req_seen[i]) begin
				req_seen[i] = 0;
				status_seen[i] = 0;
			end
		endfunction

		function void shift_in(int unsigned at, logic [VAL_W-1:0] v);
			for (int i = used; i > at; i--)
				slots[i] = slots[i-1];
			slots[at] = v;
			used++;
		endfunction

		function logic [VAL_W-1:0] shift_out(int unsigned at);
			logic [VAL_W-1:0] v;
			v = slots[at];
			for (int i = at; i + 1 < used; i++)
				slots[i] = slots[i+1];
			used--;
			return v;
		endfunction

		function void note_request(req_t r, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
			int unsigned lim;
			bit          full;
			outcome_t    o;
			lim = (cap < DEPTH_DEF) ? cap : DEPTH_DEF;
			full = used >= lim;
			o.removed = '0;
			o.st = ST_OK;
			case (r)
				REQ_APPEND: begin
					if (full) o.st = ST_FULL;
					else shift_in(used, v);
				end
				REQ_INSERT: begin
					if (full) o.st = ST_FULL;
					else if (p > used) o.st = ST_BADPOS;
					else shift_in(p, v);
				end
				REQ_POP: begin
					if (used == 0) o.st = ST_EMPTY;
					else o.removed = shift_out(0);
				end
				default: begin
					if (used == 0) o.st = ST_EMPTY;
					else if (p >= used) o.st = ST_BADPOS;
					else o.removed = shift_out(p);
				end
			endcase
			o.cnt = used[CNT_W-1:0];
			req_seen[r]++;
			status_seen[o.st]++;
			awaited.push_back(o);
		endfunction

		function void check_result(logic [VAL_W-1:0] rv, logic [1:0] st,
			logic [CNT_W-1:0] cnt);
			outcome_t o;
			if (awaited.size() == 0) begin
				$display("%0t: result word with nothing outstanding (%h %0d %0d)",
					$time, rv, st, cnt);
				errors++;
				return;
			end
			o = awaited.pop_front();
			if (rv !== o.removed) begin
				$display("%0t: removed_value expected %h got %h", $time, o.removed, rv);
				errors++;
			end
			if (st !== o.st) begin
				$display("%0t: status expected %0d got %0d", $time, o.st, st);
				errors++;
			end
			if (cnt !== o.cnt) begin
				$display("%0t: count_after expected %0d got %0d", $time, o.cnt, cnt);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              req_type = REQ_APPEND;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] new_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] removed_value;
	logic [1:0]              status;
	logic [CNT_W-1:0]        count_after;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CNT_W-1:0]        cfg_data = '0;

	list_scoreboard sb;
	int             burst_left = 0;
	int             cap_writes = 0;
	int             idle_cycles = 0;
	rx_mode_t       rx_mode = RX_STREAM;
	int             rx_left = 0;

	array_list_insert_delete dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.position      (position),
		.new_value     (new_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.removed_value (removed_value),
		.status        (status),
		.count_after   (count_after),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: switches at random between streaming and stall patterns.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(3));
			rx_left <= $urandom_range(40, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_STREAM:      out_ready <= 1'b1;
			RX_COIN:        out_ready <= ($urandom_range(1) != 0);
			RX_EVERY_THIRD: out_ready <= (rx_left % 3) != 0;
			default:        out_ready <= ($urandom_range(3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(removed_value, status, count_after);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Present one request, hold it until taken, then maybe end the burst.
	task automatic drive_request(input req_t r, input logic [POS_W-1:0] p,
		input logic [VAL_W-1:0] v);
		int gap;
		in_valid <= 1'b1;
		req_type <= r;
		position <= p;
		new_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r, p, v);
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// Only touched with nothing in flight.
	task automatic write_capacity(input logic [CNT_W-1:0] c);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.cap = c;
		cap_writes++;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(99) < 12) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// add_pct steers the list toward growing or shrinking.
	task automatic run_phase(input int words, input int add_pct);
		req_t             r;
		logic [POS_W-1:0] p;
		int unsigned      n;
		for (int i = 0; i < words; i++) begin
			n = sb.used;
			if ($urandom_range(99) < 6) begin
				r = req_t'($urandom_range(3));
				p = POS_W'($urandom_range(31));
			end else if ($urandom_range(99) < add_pct) begin
				r = $urandom_range(1) ? REQ_INSERT : REQ_APPEND;
				p = POS_W'($urandom_range(n, 0));
			end else begin
				r = $urandom_range(1) ? REQ_DELETE : REQ_POP;
				p = (n == 0) ? '0 : POS_W'($urandom_range(n - 1, 0));
			end
			// some positions drawn from the full 0 to 31 range on top of the noise words
			if ($urandom_range(99) < 15)
				p = POS_W'($urandom_range(31));
			drive_request(r, p, pick_value());
		end
	endtask

	initial begin
		logic [CNT_W-1:0] caps [9];
		int               bias [9];
		sb = new();
		caps = '{5'd31, 5'd16, 5'd3, 5'd0, 5'd9, 5'd2, 5'd16, 5'd31, 5'd0};
		bias = '{85, 45, 60, 50, 80, 30, 90, 15, 55};
		caps[8] = CNT_W'($urandom_range(31));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_capacity(CAP_RST);

		// empty list, bad positions, extremes, shifts at head, middle and tail
		drive_request(REQ_POP, 0, 32'h1111_1111);
		drive_request(REQ_DELETE, 31, 0);
		drive_request(REQ_INSERT, 1, 32'h2222_2222);
		drive_request(REQ_INSERT, 0, 32'h8000_0000);
		drive_request(REQ_APPEND, 31, 32'h7FFF_FFFF);
		drive_request(REQ_APPEND, 0, 32'h0000_0000);
		drive_request(REQ_APPEND, 0, 32'hFFFF_FFFF);
		drive_request(REQ_INSERT, 2, 32'h5555_5555);
		drive_request(REQ_INSERT, 5, 32'hAAAA_AAAA);
		drive_request(REQ_INSERT, 7, 32'h3333_3333);
		drive_request(REQ_INSERT, 31, 32'h4444_4444);
		drive_request(REQ_DELETE, 6, 0);
		drive_request(REQ_DELETE, 31, 0);
		drive_request(REQ_DELETE, 5, 0);
		drive_request(REQ_DELETE, 2, 0);
		drive_request(REQ_DELETE, 0, 0);
		drive_request(REQ_POP, 31, 32'hFFFF_FFFF);

		// capacity under the current count: full, but entries still removable
		write_capacity(5'd1);
		drive_request(REQ_APPEND, 0, 32'h1234_5678);
		drive_request(REQ_INSERT, 31, 32'h1234_5678);
		drive_request(REQ_INSERT, 0, 32'h1234_5678);
		drive_request(REQ_POP, 0, 0);
		drive_request(REQ_APPEND, 0, 32'h1234_5678);

		write_capacity(5'd0);
		drive_request(REQ_INSERT, 0, 32'h0F0F_0F0F);
		drive_request(REQ_DELETE, 0, 0);
		drive_request(REQ_DELETE, 0, 0);

		for (int ph = 0; ph < 9; ph++) begin
			write_capacity(caps[ph]);
			run_phase(PHASE_WORDS, bias[ph]);
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d requests (%0d append, %0d insert, %0d pop, %0d delete)",
			sb.req_seen[REQ_APPEND] + sb.req_seen[REQ_INSERT] + sb.req_seen[REQ_POP]
			+ sb.req_seen[REQ_DELETE], sb.req_seen[REQ_APPEND], sb.req_seen[REQ_INSERT],
			sb.req_seen[REQ_POP], sb.req_seen[REQ_DELETE]);
		$display("%0d capacity writes; %0d ok, %0d full, %0d empty, %0d bad position",
			cap_writes, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
			sb.status_seen[ST_EMPTY], sb.status_seen[ST_BADPOS]);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

@@ array_list_insert_delete.f @@
+incdir+rtl/core
rtl/core/ali_pkg.sv
rtl/core/ali_cell.sv
rtl/core/array_list_insert_delete.sv
tb/testbench.sv
